>>> hw/rtl/edsm_pkg.sv
package edsm_pkg;

    localparam int MAX_STOPS   = 256;
    localparam int NODE_W      = 8;
    localparam int ADDR_W      = 2 * NODE_W;
    localparam int TABLE_DEPTH = 1 << ADDR_W;
    localparam int DIST_W      = 31;
    localparam int COUNT_W     = $clog2(MAX_STOPS + 1);

    localparam logic [DIST_W-1:0] DIST_NONE = {DIST_W{1'b1}};

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

endpackage

>>> hw/rtl/edge_distance_store_min.sv
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             i_operation, i_node_a, i_node_b, i_distance
// result    out        o_strobe (one cycle)      o_found, o_pair_distance, o_node_count,
//                                                o_min_distance, o_min_first, o_min_second,
//                                                o_any_edge, o_max_node
//
// A request is taken in S_IDLE: the accept edge launches the table read; in
// S_EXEC the read data is seen, decided on, and at most one entry written. Busy
// is high in S_EXEC; the result strobe follows and can overlap the next accept.
// After reset the table is swept to zero, one entry a cycle, with busy high
// until all 65536 entries are clear. Results cannot be stalled.
module edge_distance_store_min
    import edsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_operation,
    input  logic [NODE_W-1:0]    i_node_a,
    input  logic [NODE_W-1:0]    i_node_b,
    input  logic [DIST_W-1:0]    i_distance,
    output logic                 o_strobe,
    output logic                 o_found,
    output logic [DIST_W-1:0]    o_pair_distance,
    output logic [COUNT_W-1:0]   o_node_count,
    output logic [DIST_W-1:0]    o_min_distance,
    output logic [NODE_W-1:0]    o_min_first,
    output logic [NODE_W-1:0]    o_min_second,
    output logic                 o_any_edge,
    output logic [NODE_W-1:0]    o_max_node
);

    // control
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                r_strobe;

    // request captured at accept
    t_op                 r_op;
    logic [NODE_W-1:0]   r_a, r_b;
    logic [DIST_W-1:0]   r_dist;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_in_range;
    logic                r_seen_a, r_seen_b;

    // running summary
    logic [MAX_STOPS-1:0] r_seen;
    logic [COUNT_W-1:0]   r_count;
    logic [DIST_W-1:0]    r_min;
    logic [NODE_W-1:0]    r_min_a, r_min_b;
    logic                 r_any;
    logic [NODE_W-1:0]    r_max;

    // result payload
    logic                r_found;
    logic [DIST_W-1:0]   r_pd;

    logic                accept;
    logic [ADDR_W-1:0]   req_addr;
    logic                req_in_range;
    logic [DIST_W-1:0]   cur;
    logic                upd;
    logic                res_found;
    logic [DIST_W-1:0]   res_pd;
    logic                inc_a, inc_b;
    logic [NODE_W-1:0]   pair_hi;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DIST_W-1:0]   ram_wdata;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // The table is symmetric, so only the ordered pair (low, high) is stored:
    // one write keeps both orders consistent.
    always_comb begin
        if (i_node_a <= i_node_b) begin
            req_addr = {i_node_a, i_node_b};
        end else begin
            req_addr = {i_node_b, i_node_a};
        end
        req_in_range = (int'(i_node_a) < MAX_STOPS) && (int'(i_node_b) < MAX_STOPS);
    end

    edsm_ram #(
        .WIDTH (DIST_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (req_addr),
        .o_rdata (cur)
    );

    // decision in the cycle the read data arrives
    always_comb begin
        upd = r_in_range && (r_op == OP_INSERT) && (r_dist != '0)
              && ((cur == '0) || (cur > r_dist));
        if (!r_in_range) begin
            res_found = 1'b0;
            res_pd    = '0;
        end else if (r_op == OP_QUERY) begin
            res_found = (cur != '0);
            res_pd    = cur;
        end else begin
            res_found = upd;
            res_pd    = upd ? r_dist : cur;
        end
        inc_a   = !r_seen_a;
        inc_b   = !r_seen_b && (r_a != r_b);
        pair_hi = (r_a > r_b) ? r_a : r_b;
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_EXEC) && upd;
            ram_waddr = r_addr;
            ram_wdata = r_dist;
        end
    end

    always_comb begin
        case (r_state)
            S_CLEAR: n_state = (r_clr_addr == {ADDR_W{1'b1}}) ? S_IDLE : S_CLEAR;
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
            r_seen     <= '0;
            r_count    <= '0;
            r_min      <= DIST_NONE;
            r_min_a    <= '0;
            r_min_b    <= '0;
            r_any      <= 1'b0;
            r_max      <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_EXEC);
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if ((r_state == S_EXEC) && upd) begin
                r_seen[r_a] <= 1'b1;
                r_seen[r_b] <= 1'b1;
                r_count     <= r_count + COUNT_W'(inc_a) + COUNT_W'(inc_b);
                if (r_dist < r_min) begin
                    r_min   <= r_dist;
                    r_min_a <= r_a;
                    r_min_b <= r_b;
                end
                if (pair_hi > r_max) begin
                    r_max <= pair_hi;
                end
                r_any <= 1'b1;
            end
        end
    end

    // payload, no reset; seen marks are sampled at accept, they only change in S_EXEC
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= t_op'(i_operation);
            r_a        <= i_node_a;
            r_b        <= i_node_b;
            r_dist     <= i_distance;
            r_addr     <= req_addr;
            r_in_range <= req_in_range;
            r_seen_a   <= r_seen[i_node_a];
            r_seen_b   <= r_seen[i_node_b];
        end
        if (r_state == S_EXEC) begin
            r_found <= res_found;
            r_pd    <= res_pd;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_found         = r_found;
    assign o_pair_distance = r_pd;
    assign o_node_count    = r_count;
    assign o_min_distance  = r_min;
    assign o_min_first     = r_min_a;
    assign o_min_second    = r_min_b;
    assign o_any_edge      = r_any;
    assign o_max_node      = r_max;

endmodule

>>> hw/rtl/edsm_ram.sv
module edsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top
    import edsm_pkg::*;
();

    // The table sweep after reset keeps busy high until every entry is cleared, with
    // nothing accepted, so the quiet-cycle limit must sit well above the table depth.
    localparam int QUIET_LIMIT  = 3 * TABLE_DEPTH;
    localparam int DRAIN_CYCLES = 8;
    localparam int RESET_CYCLES = 10;

    typedef struct packed {
        logic               found;
        logic [DIST_W-1:0]  pair_dist;
        logic [COUNT_W-1:0] stop_count;
        logic [DIST_W-1:0]  min_dist;
        logic [NODE_W-1:0]  min_a;
        logic [NODE_W-1:0]  min_b;
        logic               any_edge;
        logic [NODE_W-1:0]  max_stop;
    } t_reply;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_operation;
    logic [NODE_W-1:0]  i_node_a;
    logic [NODE_W-1:0]  i_node_b;
    logic [DIST_W-1:0]  i_distance;
    logic               o_strobe;
    logic               o_found;
    logic [DIST_W-1:0]  o_pair_distance;
    logic [COUNT_W-1:0] o_node_count;
    logic [DIST_W-1:0]  o_min_distance;
    logic [NODE_W-1:0]  o_min_first;
    logic [NODE_W-1:0]  o_min_second;
    logic               o_any_edge;
    logic [NODE_W-1:0]  o_max_node;

    // Shadow copy of the block's state, updated at each accepted request.
    logic [DIST_W-1:0]  link_dist [TABLE_DEPTH];
    logic               stop_marked [MAX_STOPS];
    logic [COUNT_W-1:0] marked_count;
    logic [DIST_W-1:0]  low_dist;
    logic [NODE_W-1:0]  low_a;
    logic [NODE_W-1:0]  low_b;
    logic               have_edge;
    logic [NODE_W-1:0]  top_stop;

    // Replies owed by the block, oldest first.
    t_reply table_replies [$];

    int fail_count   = 0;
    int quiet_cycles = 0;

    edge_distance_store_min dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_node_a        (i_node_a),
        .i_node_b        (i_node_b),
        .i_distance      (i_distance),
        .o_strobe        (o_strobe),
        .o_found         (o_found),
        .o_pair_distance (o_pair_distance),
        .o_node_count    (o_node_count),
        .o_min_distance  (o_min_distance),
        .o_min_first     (o_min_first),
        .o_min_second    (o_min_second),
        .o_any_edge      (o_any_edge),
        .o_max_node      (o_max_node)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void mark_stop(input logic [NODE_W-1:0] s);
        if (!stop_marked[s]) begin
            stop_marked[s] = 1'b1;
            marked_count   = marked_count + 1'b1;
        end
    endfunction

    // Applies one request to the shadow state and returns the reply it owes.
    // Every 8-bit stop is below MAX_STOPS, so the out-of-range path never runs.
    function automatic t_reply table_update(input t_op op, input logic [NODE_W-1:0] a,
                                            input logic [NODE_W-1:0] b,
                                            input logic [DIST_W-1:0] d);
        t_reply            r;
        logic [DIST_W-1:0] cur;
        cur         = link_dist[{a, b}];
        r.found     = 1'b0;
        r.pair_dist = cur;
        if (op == OP_INSERT) begin
            // write only when the pair is empty or holds a strictly larger distance
            if (d != '0 && (cur == '0 || cur > d)) begin
                link_dist[{a, b}] = d;
                link_dist[{b, a}] = d;
                mark_stop(a);
                mark_stop(b);
                // ties keep the older pair
                if (d < low_dist) begin
                    low_dist = d;
                    low_a    = a;
                    low_b    = b;
                end
                if (a > top_stop) top_stop = a;
                if (b > top_stop) top_stop = b;
                have_edge   = 1'b1;
                r.found     = 1'b1;
                r.pair_dist = d;
            end
        end else begin
            r.found = (cur != '0);
        end
        r.stop_count = marked_count;
        r.min_dist   = low_dist;
        r.min_a      = low_a;
        r.min_b      = low_b;
        r.any_edge   = have_edge;
        r.max_stop   = top_stop;
        return r;
    endfunction

    // Sends one request: random idle gap first, then hold start until busy is low
    // at an edge. The shadow state is advanced at the accepting edge.
    task automatic send_request(input t_op op, input logic [NODE_W-1:0] a,
                                input logic [NODE_W-1:0] b,
                                input logic [DIST_W-1:0] d, input int idle_pct);
        t_reply owed;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_node_a    <= a;
        i_node_b    <= b;
        i_distance  <= d;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        owed          = table_update(op, a, b, d);
        table_replies = {table_replies, owed};
    endtask

    // Hand-picked corner cases, back to back.
    task automatic test_directed();
        send_request(OP_QUERY,  8'd0,   8'd0,   31'd0,          0); // empty table
        send_request(OP_INSERT, 8'd3,   8'd7,   31'd0,          0); // zero distance ignored
        send_request(OP_INSERT, 8'd3,   8'd7,   DIST_NONE,      0); // full-scale edge: min pair stays 0,0
        send_request(OP_QUERY,  8'd7,   8'd3,   31'd0,          0); // reverse order sees it
        send_request(OP_INSERT, 8'd3,   8'd7,   31'd1000,       0); // smaller replaces larger
        send_request(OP_INSERT, 8'd7,   8'd3,   31'd1000,       0); // equal: no write
        send_request(OP_INSERT, 8'd3,   8'd7,   31'd2000,       0); // larger: no write
        send_request(OP_QUERY,  8'd3,   8'd7,   31'd0,          0);
        send_request(OP_INSERT, 8'd0,   8'd255, 31'd1,          0); // extreme stops, smallest distance
        send_request(OP_INSERT, 8'd255, 8'd255, 31'd5,          0); // self pair, stop already counted
        send_request(OP_QUERY,  8'd255, 8'd255, DIST_NONE,      0); // distance ignored on query
        send_request(OP_INSERT, 8'd255, 8'd0,   31'd1,          0); // equal on the mirror entry
        send_request(OP_INSERT, 8'd128, 8'd1,   31'd1,          0); // minimum tie keeps old pair
        send_request(OP_QUERY,  8'd1,   8'd128, 31'd0,          0);
        send_request(OP_INSERT, 8'd9,   8'd9,   31'h5555_5555,  0); // alternating bits
        send_request(OP_INSERT, 8'd10,  8'd11,  31'h2AAA_AAAA,  0);
        send_request(OP_QUERY,  8'd11,  8'd10,  31'h7FFF_FFFF,  0);
        send_request(OP_QUERY,  8'd100, 8'd200, 31'd0,          0); // never connected
        send_request(OP_INSERT, 8'd10,  8'd11,  31'h2AAA_AAA9,  0); // replace by one less
        send_request(OP_QUERY,  8'd0,   8'd255, 31'd0,          0);
    endtask

    // Covers every stop so the stop count reaches MAX_STOPS.
    task automatic test_all_stops(input int idle_pct);
        for (int k = 0; k < MAX_STOPS / 2; k++) begin
            send_request(OP_INSERT, NODE_W'(2 * k), NODE_W'(2 * k + 1),
                         DIST_W'($urandom_range(32'h4000_0000, 32'h0010_0000)), idle_pct);
        end
    endtask

    // Mostly requests within a narrow window of stops so pairs repeat and small
    // distances keep replacing each other; the rest span the full field ranges.
    task automatic test_random(input int count, input int idle_pct);
        logic [NODE_W-1:0] base;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic [DIST_W-1:0] d;
        t_op               op;
        int                burst_left;
        int                pick;
        burst_left = 0;
        base       = '0;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                base       = NODE_W'($urandom_range(255));
                burst_left = ($urandom_range(3) == 0) ? 40 : 0; // stretch with no gaps
            end
            op = ($urandom_range(99) < 40) ? OP_QUERY : OP_INSERT;
            if ($urandom_range(99) < 80) begin
                a = base + NODE_W'($urandom_range(7));
                b = base + NODE_W'($urandom_range(7));
            end else begin
                a = NODE_W'($urandom);
                b = NODE_W'($urandom);
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                d = '0;
            end else if (pick < 70) begin
                d = DIST_W'($urandom_range(64, 1));
            end else if (pick < 90) begin
                d = DIST_W'($urandom);
            end else begin
                d = DIST_NONE - DIST_W'($urandom_range(3));
            end
            send_request(op, a, b, d, (burst_left > 0) ? 0 : idle_pct);
            if (burst_left > 0) burst_left--;
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Results cannot be held off: every strobe is checked against the oldest reply.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (table_replies.size() == 0) begin
                $error("result strobe with no request pending");
                fail_count++;
            end else begin
                want = table_replies.pop_front();
                check_field("found",         64'(want.found),      64'(o_found));
                check_field("pair_distance", 64'(want.pair_dist),  64'(o_pair_distance));
                check_field("node_count",    64'(want.stop_count), 64'(o_node_count));
                check_field("min_distance",  64'(want.min_dist),   64'(o_min_distance));
                check_field("min_first",     64'(want.min_a),      64'(o_min_first));
                check_field("min_second",    64'(want.min_b),      64'(o_min_second));
                check_field("any_edge",      64'(want.any_edge),   64'(o_any_edge));
                check_field("max_node",      64'(want.max_stop),   64'(o_max_node));
            end
        end
    end

    // Watchdog: too many cycles with neither a request nor a result accepted.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("edge_distance_store_min test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        start       <= 1'b0;
        i_operation <= OP_INSERT;
        i_node_a    <= '0;
        i_node_b    <= '0;
        i_distance  <= '0;
        i_rst_n     <= 1'b0;

        for (int i = 0; i < TABLE_DEPTH; i++) link_dist[i] = '0;
        for (int i = 0; i < MAX_STOPS; i++) stop_marked[i] = 1'b0;
        marked_count = '0;
        low_dist     = DIST_NONE;
        low_a        = '0;
        low_b        = '0;
        have_edge    = 1'b0;
        top_stop     = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the first request waits out the table sweep
        test_directed();
        test_all_stops(77);
        test_random(500, 0);
        test_random(500, 77);
        test_random(500, 27);
        start <= 1'b0;

        while (table_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("edge_distance_store_min test passed");
        end else begin
            $display("edge_distance_store_min test failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/edsm_pkg.sv
hw/rtl/edsm_ram.sv
hw/rtl/edge_distance_store_min.sv
sim/tb_top.sv
